// ===== rtl/wps_pkg.sv =====
`timescale 1ns / 1ps
// Package for the waypoint path stepper: command codes, register indexes,
// sequencer states, shared structs and small arithmetic helpers.
// No dependencies.
package wps_pkg;

  localparam int WPS_MAX_POINTS = 16;
  localparam int WPS_MUL_W      = 34;
  localparam int WPS_PROD_W     = 68;
  localparam int WPS_SQRT_STEPS = 34;
  localparam int WPS_DIV_STEPS  = 31;
  localparam logic [47:0] WPS_STEP_CAP = 48'h0002_0000_0000;
  localparam logic [31:0] WPS_RADIUS_RST = 32'd131072;

  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_CLEAR  = 3'd1;
  localparam logic [2:0] MODE_SETPOS = 3'd2;
  localparam logic [2:0] MODE_START  = 3'd3;
  localparam logic [2:0] MODE_TICK   = 3'd4;

  localparam logic CFG_LOOP   = 1'b0;
  localparam logic CFG_RADIUS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_DIFF, ST_SQ, ST_SQRT, ST_SQRTW, ST_STEP, ST_STEPW,
    ST_DIV, ST_DIVW, ST_MOVE, ST_MOVEW, ST_RAD, ST_CMP, ST_FIN
  } wps_state_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } wps_iter_req_t;

  typedef struct packed {
    logic [31:0] spd;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } wps_point_t;

  // magnitude of a 33-bit signed difference
  function automatic logic [33:0] wps_mag(input logic [32:0] d);
    return d[32] ? (~{d[32], d} + 34'd1) : {1'b0, d};
  endfunction

  // add a signed move to a coordinate and saturate to 32 bits
  function automatic logic [31:0] wps_step_axis(input logic [31:0] cur,
                                                input logic neg,
                                                input logic [33:0] m);
    logic [35:0] mv;
    logic [35:0] sum;
    mv  = neg ? (36'd0 - {2'b00, m}) : {2'b00, m};
    sum = {{4{cur[31]}}, cur} + mv;
    if ($signed(sum) > 36'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if ($signed(sum) < -36'sd2147483648) begin
      return 32'h8000_0000;
    end
    return sum[31:0];
  endfunction

endpackage

// ===== rtl/waypoint_path_stepper_unit.sv =====
`timescale 1ns / 1ps
// Top level of the waypoint path stepper: sequencer, state registers and
// result register. Depends on wps_pkg, wps_table, wps_mul and wps_iter.
//
// Usage: each request on the in_ stream carries a command in in_tuser
// (append, clear, set position, start, tick) and its operands in in_tdata.
// Every request yields exactly one result on the out_ stream: position,
// run flag, target index, arrival and table-full flags.
// Append, clear, set position, start and a tick with no waypoint left
// complete at once: the result is registered at the accepting edge.
// A moving tick runs one shared multiplier and one shared shift-subtract
// unit under the sequencer: a 34-step square root and up to three
// 31-step divides, one per axis.
// in_tready is low while a tick is worked on.
// Reset (rst_n low, synchronous) empties the table, zeroes the position,
// index and run flag, and sets loop_enable 0 and reach_radius 2.0.
// A stalled out_tready holds the result; a new request is taken only once
// the result register is free or being emptied in the same cycle.
module waypoint_path_stepper_unit import wps_pkg::*; #(
  parameter int MAX_POINTS = WPS_MAX_POINTS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // fields from bit 0: coord_x[31:0], coord_y[63:32], coord_z[95:64],
  // waypoint_speed[127:96], elapsed_time[159:128]
  input  logic [159:0] in_tdata,
  // fields from bit 0: mode[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // fields from bit 0: pos_x[31:0], pos_y[63:32], pos_z[95:64],
  // moving_flag[96], target_index[101:97], arrived[102], table_full[103]
  output logic [103:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int IW = $clog2(MAX_POINTS + 1);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  wps_state_t state_r, state_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          active_r, active_nxt;
  logic [31:0]   cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic          loop_r;
  logic [31:0]   radius_r;
  logic [31:0]   elapsed_r, elapsed_nxt;
  logic [32:0]   dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [67:0]   acc_r, acc_nxt;
  logic [33:0]   len_r, len_nxt;
  logic [33:0]   step_r, step_nxt;
  logic [30:0]   dir_r, dir_nxt;
  logic [1:0]    axis_r, axis_nxt;
  logic [1:0]    sqk_r, sqk_nxt;
  logic          pass_r, pass_nxt;
  logic          arrived_r, arrived_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [103:0]  out_data_r, out_data_nxt;

  logic          load_out;
  logic          full_f;
  logic          in_acc;
  logic          tbl_we;
  wps_point_t    tbl_wdata, tgt;
  logic [WPS_MUL_W-1:0]  mul_a, mul_b;
  logic [WPS_PROD_W-1:0] prod;
  wps_iter_req_t iter_req;
  logic          iter_done;
  logic [33:0]   iter_quo;
  logic [32:0]   d_sel;
  logic [33:0]   d_mag;
  logic [31:0]   idx_ext;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign tbl_wdata = '{spd: in_tdata[127:96], z: in_tdata[95:64],
                       y: in_tdata[63:32], x: in_tdata[31:0]};

  wps_table #(.DEPTH(MAX_POINTS), .AW(AW)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (count_r[AW-1:0]),
    .wdata (tbl_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (tgt)
  );

  wps_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    case (axis_r)
      2'd0:    d_sel = dx_r;
      2'd1:    d_sel = dy_r;
      default: d_sel = dz_r;
    endcase
  end

  assign d_mag = wps_mag(d_sel);

  wps_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (iter_req),
    .rad     (acc_r),
    .num_mag (d_mag[32:0]),
    .den     (len_r),
    .done    (iter_done),
    .quo     (iter_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      active_r    <= 1'b0;
      cx_r        <= '0;
      cy_r        <= '0;
      cz_r        <= '0;
      loop_r      <= 1'b0;
      radius_r    <= WPS_RADIUS_RST;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
      arrived_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      active_r    <= active_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      cz_r        <= cz_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
      arrived_r   <= arrived_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOOP:   loop_r   <= cfg_wdata[0];
          CFG_RADIUS: radius_r <= cfg_wdata;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r  <= elapsed_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dz_r       <= dz_nxt;
    acc_r      <= acc_nxt;
    len_r      <= len_nxt;
    step_r     <= step_nxt;
    dir_r      <= dir_nxt;
    axis_r     <= axis_nxt;
    sqk_r      <= sqk_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    logic [47:0] s48;
    logic [33:0] m;
    logic [31:0] cur_sel;
    logic [31:0] new_pos;
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    active_nxt  = active_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    cz_nxt      = cz_r;
    elapsed_nxt = elapsed_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    dz_nxt      = dz_r;
    acc_nxt     = acc_r;
    len_nxt     = len_r;
    step_nxt    = step_r;
    dir_nxt     = dir_r;
    axis_nxt    = axis_r;
    sqk_nxt     = sqk_r;
    pass_nxt    = pass_r;
    arrived_nxt = arrived_r;
    load_out    = 1'b0;
    full_f      = 1'b0;
    tbl_we      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    iter_req    = '0;
    s48         = prod[63:16];
    m           = prod[63:30];
    case (axis_r)
      2'd0:    cur_sel = cx_r;
      2'd1:    cur_sel = cy_r;
      default: cur_sel = cz_r;
    endcase
    new_pos = wps_step_axis(cur_sel, d_sel[32], m);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          elapsed_nxt = in_tdata[159:128];
          arrived_nxt = 1'b0;
          pass_nxt    = 1'b0;
          load_out    = 1'b1;
          case (in_tuser)
            MODE_APPEND: begin
              if (count_r >= IW'(MAX_POINTS)) begin
                full_f = 1'b1;
              end else begin
                tbl_we    = 1'b1;
                count_nxt = count_r + IW'(1);
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
              idx_nxt   = '0;
            end
            MODE_SETPOS: begin
              cx_nxt = in_tdata[31:0];
              cy_nxt = in_tdata[63:32];
              cz_nxt = in_tdata[95:64];
            end
            MODE_START: begin
              idx_nxt    = '0;
              active_nxt = 1'b1;
            end
            MODE_TICK: begin
              if (idx_r < count_r) begin
                load_out  = 1'b0;
                state_nxt = ST_LOAD;
              end else if (loop_r) begin
                idx_nxt = '0;
              end else begin
                active_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      // wait for the table read at the target index
      ST_LOAD: state_nxt = ST_DIFF;
      ST_DIFF: begin
        dx_nxt    = {tgt.x[31], tgt.x} - {cx_r[31], cx_r};
        dy_nxt    = {tgt.y[31], tgt.y} - {cy_r[31], cy_r};
        dz_nxt    = {tgt.z[31], tgt.z} - {cz_r[31], cz_r};
        sqk_nxt   = 2'd0;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        sqk_nxt = sqk_r + 2'd1;
        case (sqk_r)
          2'd0: begin
            mul_a = wps_mag(dx_r);
            mul_b = wps_mag(dx_r);
          end
          2'd1: begin
            acc_nxt = prod;
            mul_a   = wps_mag(dy_r);
            mul_b   = wps_mag(dy_r);
          end
          2'd2: begin
            acc_nxt = acc_r + prod;
            mul_a   = wps_mag(dz_r);
            mul_b   = wps_mag(dz_r);
          end
          default: begin
            acc_nxt   = acc_r + prod;
            state_nxt = pass_r ? ST_RAD : ST_SQRT;
          end
        endcase
      end
      ST_SQRT: begin
        iter_req  = '{start: 1'b1, is_sqrt: 1'b1};
        state_nxt = ST_SQRTW;
      end
      ST_SQRTW: begin
        if (iter_done) begin
          len_nxt   = iter_quo;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        mul_a     = {2'b00, tgt.spd};
        mul_b     = {2'b00, elapsed_r};
        state_nxt = ST_STEPW;
      end
      ST_STEPW: begin
        step_nxt  = (s48 > WPS_STEP_CAP) ? WPS_STEP_CAP[33:0] : s48[33:0];
        axis_nxt  = 2'd0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (len_r == 34'd0) begin
          dir_nxt   = '0;
          state_nxt = ST_MOVE;
        end else begin
          iter_req  = '{start: 1'b1, is_sqrt: 1'b0};
          state_nxt = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (iter_done) begin
          dir_nxt   = iter_quo[30:0];
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        mul_a     = {3'b000, dir_r};
        mul_b     = step_r;
        state_nxt = ST_MOVEW;
      end
      ST_MOVEW: begin
        case (axis_r)
          2'd0:    cx_nxt = new_pos;
          2'd1:    cy_nxt = new_pos;
          default: cz_nxt = new_pos;
        endcase
        if (axis_r == 2'd2) begin
          pass_nxt  = 1'b1;
          state_nxt = ST_DIFF;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_DIV;
        end
      end
      ST_RAD: begin
        mul_a     = {2'b00, radius_r};
        mul_b     = {2'b00, radius_r};
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // snap onto the waypoint and advance when within reach
        if (acc_r <= prod) begin
          cx_nxt      = tgt.x;
          cy_nxt      = tgt.y;
          cz_nxt      = tgt.z;
          idx_nxt     = idx_r + IW'(1);
          arrived_nxt = 1'b1;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idx_ext = 32'(idx_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {full_f, arrived_nxt, idx_ext[4:0], active_nxt,
                       cz_nxt, cy_nxt, cx_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/wps_table.sv =====
`timescale 1ns / 1ps
// Waypoint table: one memory word per waypoint (x, y, z, speed).
// Depends on wps_pkg.
module wps_table import wps_pkg::*; #(
  parameter int DEPTH = WPS_MAX_POINTS,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  wps_point_t    wdata,
  input  logic [AW-1:0] raddr,
  output wps_point_t    rdata
);

  wps_point_t mem [DEPTH];
  wps_point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wps_mul.sv =====
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on wps_pkg.
module wps_mul import wps_pkg::*; (
  input  logic                  clk,
  input  logic [WPS_MUL_W-1:0]  a,
  input  logic [WPS_MUL_W-1:0]  b,
  output logic [WPS_PROD_W-1:0] prod
);

  logic [WPS_PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

// ===== rtl/wps_iter.sv =====
`timescale 1ns / 1ps
// Shared shift-subtract unit: integer square root (two bits a step) or
// restoring division (one bit a step). Depends on wps_pkg.
module wps_iter import wps_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  wps_iter_req_t req,
  input  logic [67:0]   rad,
  input  logic [32:0]   num_mag,
  input  logic [33:0]   den,
  output logic          done,
  output logic [33:0]   quo
);

  logic [37:0] rem_r;
  logic [33:0] quo_r;
  logic [67:0] src_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        sqrt_r;
  logic        done_r;
  logic [37:0] sh;
  logic [37:0] trial;
  logic        ge;

  always_comb begin
    sh    = sqrt_r ? {rem_r[35:0], src_r[67:66]} : {rem_r[36:0], src_r[67]};
    trial = sqrt_r ? {2'b00, quo_r, 2'b01} : {4'b0000, den};
    ge    = (sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        sqrt_r <= req.is_sqrt;
        quo_r  <= '0;
        if (req.is_sqrt) begin
          rem_r <= '0;
          src_r <= rad;
          cnt_r <= 6'(WPS_SQRT_STEPS - 1);
        end else begin
          // the quotient stays below 2^31, so start with the top bits in place
          rem_r <= {6'd0, num_mag[32:1]};
          src_r <= {num_mag[0], 67'd0};
          cnt_r <= 6'(WPS_DIV_STEPS - 1);
        end
      end else if (busy_r) begin
        rem_r <= ge ? (sh - trial) : sh;
        quo_r <= {quo_r[32:0], ge};
        src_r <= sqrt_r ? {src_r[65:0], 2'b00} : {src_r[66:0], 1'b0};
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
